>>> rtl/core/sct_pkg.sv
// sleep countdown table: shared types, codes and field widths
// no dependencies; imported by the interfaces, the slot ram, the core and the checker
`timescale 1ns / 1ps

package sct_pkg;

  // field widths
  localparam int IdW    = 16;
  localparam int TicksW = 32;
  localparam int RemW   = 31;
  localparam int FuncW  = 2;
  localparam int KindW  = 3;

  // request function codes
  typedef enum logic [FuncW-1:0] {
    FUNC_PUT    = 2'd0,
    FUNC_TICK   = 2'd1,
    FUNC_REMOVE = 2'd2,
    FUNC_NONE   = 2'd3
  } func_e;

  // result kinds
  typedef enum logic [KindW-1:0] {
    KIND_PUT_OK    = 3'd0,
    KIND_PUT_REJ   = 3'd1,
    KIND_WOKEN     = 3'd2,
    KIND_REMOVED   = 3'd3,
    KIND_NOT_FOUND = 3'd4
  } kind_e;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_e;

  // one table entry
  typedef struct packed {
    logic [IdW-1:0]  thread;
    logic [RemW-1:0] remaining;
  } slot_t;

endpackage

>>> rtl/core/sct_if.sv
// sleep countdown table: request and result channel interfaces
// depends on sct_pkg for field widths
`timescale 1ns / 1ps

interface sct_in_if import sct_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [FuncW-1:0]         func;
  logic                     has_running;
  logic [IdW-1:0]           thread_id;
  logic signed [TicksW-1:0] sleep_ticks;

  modport source (output valid, func, has_running, thread_id, sleep_ticks, input ready);
  modport sink   (input valid, func, has_running, thread_id, sleep_ticks, output ready);
endinterface

interface sct_out_if import sct_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [KindW-1:0] kind;
  logic [IdW-1:0]   woken_id;
  logic             last;

  modport source (output valid, kind, woken_id, last, input ready);
  modport sink   (input valid, kind, woken_id, last, output ready);
endinterface

>>> rtl/core/sct_slot_ram.sv
// sleep countdown table: slot storage, one write port and one registered read port
// depends on sct_pkg for the slot type
`timescale 1ns / 1ps

module sct_slot_ram import sct_pkg::*; #(
  parameter int AddrW = 4
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  slot_t            wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output slot_t            rdata_o
);

  localparam int Depth = 1 << AddrW;

  slot_t mem_q [Depth];
  slot_t rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port, holds while not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/core/sleep_countdown_table_core.sv
// sleep countdown table core: a put result goes through ST_DONE to the output register;
// tick and remove scan the occupied slots, one slot per cycle unless a result stalls at
// the output (single ram read port, shared compare/decrement), then finish in ST_DONE.
// one request at a time: ready is high only while idle. func code 3 is accepted and ignored.
// reset (async, active low) empties the table and clears control; ram contents are not cleared.
// depends on sct_pkg, sct_in_if, sct_out_if and sct_slot_ram
`timescale 1ns / 1ps

module sleep_countdown_table_core import sct_pkg::*; #(
  parameter int MAX_SLEEPERS = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  sct_in_if.sink    in_i,
  sct_out_if.source out_o
);

  localparam int AddrW = (MAX_SLEEPERS > 1) ? $clog2(MAX_SLEEPERS) : 1;
  localparam int CntW  = $clog2(MAX_SLEEPERS + 1);
  localparam logic [CntW-1:0] MaxCnt = CntW'(MAX_SLEEPERS);

  // sequencer and table state
  state_e            state_q, state_d;
  logic [CntW-1:0]   count_q, count_d;
  logic [AddrW-1:0]  head_q, head_d;
  logic [CntW-1:0]   idx_q, idx_d;
  logic [CntW-1:0]   wr_q, wr_d;
  logic              found_q, found_d;
  func_e             func_q, func_d;
  logic [IdW-1:0]    id_q, id_d;

  // pending result, held until the next one shows whether it is the last
  logic              pend_vld_q, pend_vld_d;
  kind_e             pend_kind_q, pend_kind_d;
  logic [IdW-1:0]    pend_id_q, pend_id_d;

  // output register
  logic              out_vld_q, out_vld_d;
  kind_e             out_kind_q, out_kind_d;
  logic [IdW-1:0]    out_id_q, out_id_d;
  logic              out_last_q, out_last_d;

  // ram port
  logic              ram_we, ram_re;
  logic [AddrW-1:0]  ram_waddr, ram_raddr;
  slot_t             ram_wdata, ram_rdata;

  logic accept, out_free, put_ok, wake, hit, emit, stall, last_ent;

  sct_slot_ram #(.AddrW(AddrW)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign in_i.ready   = (state_q == ST_IDLE);
  assign accept       = in_i.valid && in_i.ready;
  assign out_free     = !out_vld_q || out_o.ready;
  assign out_o.valid    = out_vld_q;
  assign out_o.kind     = out_kind_q;
  assign out_o.woken_id = out_id_q;
  assign out_o.last     = out_last_q;

  // next state, ram control and result flow
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    head_d      = head_q;
    idx_d       = idx_q;
    wr_d        = wr_q;
    found_d     = found_q;
    func_d      = func_q;
    id_d        = id_q;
    pend_vld_d  = pend_vld_q;
    pend_kind_d = pend_kind_q;
    pend_id_d   = pend_id_q;
    out_vld_d   = out_vld_q && !out_o.ready;
    out_kind_d  = out_kind_q;
    out_id_d    = out_id_q;
    out_last_d  = out_last_q;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    ram_waddr   = '0;
    ram_raddr   = '0;
    ram_wdata   = '0;
    put_ok      = 1'b0;
    wake        = 1'b0;
    hit         = 1'b0;
    emit        = 1'b0;
    stall       = 1'b0;
    last_ent    = (idx_q == count_q - CntW'(1));

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          func_d  = func_e'(in_i.func);
          id_d    = in_i.thread_id;
          found_d = 1'b0;
          idx_d   = '0;
          wr_d    = '0;
          case (func_e'(in_i.func))
            FUNC_PUT: begin
              // newest entry goes just below the head of the ring
              put_ok = in_i.has_running && !in_i.sleep_ticks[TicksW-1] &&
                       (in_i.sleep_ticks != '0) && (count_q != MaxCnt);
              if (put_ok) begin
                ram_we    = 1'b1;
                ram_waddr = head_q - AddrW'(1);
                ram_wdata = '{thread: in_i.thread_id,
                              remaining: in_i.sleep_ticks[RemW-1:0]};
                head_d    = head_q - AddrW'(1);
                count_d   = count_q + CntW'(1);
              end
              pend_vld_d  = 1'b1;
              pend_kind_d = put_ok ? KIND_PUT_OK : KIND_PUT_REJ;
              pend_id_d   = '0;
              state_d     = ST_DONE;
            end
            FUNC_TICK, FUNC_REMOVE: begin
              if (count_q == '0) begin
                state_d = ST_DONE;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = head_q;
                state_d   = ST_SCAN;
              end
            end
            default: ;
          endcase
        end
      end

      ST_SCAN: begin
        // ram data holds entry idx_q, newest first
        wake  = (func_q == FUNC_TICK) && (ram_rdata.remaining == RemW'(1));
        hit   = (func_q == FUNC_REMOVE) && !found_q && (ram_rdata.thread == id_q);
        emit  = wake || hit;
        stall = emit && pend_vld_q && !out_free;
        if (!stall) begin
          if (emit) begin
            if (pend_vld_q) begin
              out_vld_d  = 1'b1;
              out_kind_d = pend_kind_q;
              out_id_d   = pend_id_q;
              out_last_d = 1'b0;
            end
            pend_vld_d  = 1'b1;
            pend_kind_d = wake ? KIND_WOKEN : KIND_REMOVED;
            pend_id_d   = ram_rdata.thread;
          end
          // tick: survivors are compacted toward the head, decremented
          if ((func_q == FUNC_TICK) && !wake) begin
            ram_we    = 1'b1;
            ram_waddr = head_q + wr_q[AddrW-1:0];
            ram_wdata = '{thread: ram_rdata.thread,
                          remaining: ram_rdata.remaining - RemW'(1)};
            wr_d      = wr_q + CntW'(1);
          end
          // remove: entries after the match move up by one
          if ((func_q == FUNC_REMOVE) && found_q) begin
            ram_we    = 1'b1;
            ram_waddr = head_q + idx_q[AddrW-1:0] - AddrW'(1);
            ram_wdata = ram_rdata;
          end
          if (hit) begin
            found_d = 1'b1;
          end
          if (last_ent) begin
            state_d = ST_DONE;
            if (func_q == FUNC_TICK) begin
              count_d = wr_d;
            end else if (found_q || hit) begin
              count_d = count_q - CntW'(1);
            end
          end else begin
            idx_d     = idx_q + CntW'(1);
            ram_re    = 1'b1;
            ram_raddr = head_q + idx_d[AddrW-1:0];
          end
        end
      end

      ST_DONE: begin
        // flush the final result with last set, or a not-found result for a failed remove
        if (pend_vld_q) begin
          if (out_free) begin
            out_vld_d  = 1'b1;
            out_kind_d = pend_kind_q;
            out_id_d   = pend_id_q;
            out_last_d = 1'b1;
            pend_vld_d = 1'b0;
            state_d    = ST_IDLE;
          end
        end else if ((func_q == FUNC_REMOVE) && !found_q) begin
          if (out_free) begin
            out_vld_d  = 1'b1;
            out_kind_d = KIND_NOT_FOUND;
            out_id_d   = '0;
            out_last_d = 1'b1;
            state_d    = ST_IDLE;
          end
        end else begin
          state_d = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      count_q    <= '0;
      head_q     <= '0;
      idx_q      <= '0;
      wr_q       <= '0;
      found_q    <= 1'b0;
      func_q     <= FUNC_NONE;
      pend_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      count_q    <= count_d;
      head_q     <= head_d;
      idx_q      <= idx_d;
      wr_q       <= wr_d;
      found_q    <= found_d;
      func_q     <= func_d;
      pend_vld_q <= pend_vld_d;
      out_vld_q  <= out_vld_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    id_q        <= id_d;
    pend_kind_q <= pend_kind_d;
    pend_id_q   <= pend_id_d;
    out_kind_q  <= out_kind_d;
    out_id_q    <= out_id_d;
    out_last_q  <= out_last_d;
  end

endmodule

>>> rtl/core/sct_checker.sv
// sleep countdown table: port-level checks, bound to the core
// depends on sct_pkg and sleep_countdown_table_core
`timescale 1ns / 1ps

module sct_checker import sct_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_ready_i,
  input logic [FuncW-1:0] in_func_i,
  input logic             out_valid_i,
  input logic             out_ready_i,
  input logic [KindW-1:0] out_kind_i,
  input logic [IdW-1:0]   out_woken_id_i,
  input logic             out_last_i
);

  // a real request keeps the core busy for at least the next cycle
  a_busy_after_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i && (in_func_i != FUNC_NONE)) |=> !in_ready_i)
    else $error("core ready right after a request");

  // only defined kinds leave the core
  a_kind_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (out_kind_i <= KIND_NOT_FOUND))
    else $error("undefined result kind");

  // put and not-found results stand alone and carry no id
  a_single_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && ((out_kind_i == KIND_PUT_OK) || (out_kind_i == KIND_PUT_REJ) ||
                     (out_kind_i == KIND_NOT_FOUND)))
    |-> (out_last_i && (out_woken_id_i == '0)))
    else $error("single result with id or without last");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=>
    (out_valid_i && $stable(out_kind_i) && $stable(out_woken_id_i) && $stable(out_last_i)))
    else $error("stalled result changed");

endmodule

bind sleep_countdown_table_core sct_checker u_sct_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_i.valid),
  .in_ready_i     (in_i.ready),
  .in_func_i      (in_i.func),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .out_kind_i     (out_o.kind),
  .out_woken_id_i (out_o.woken_id),
  .out_last_i     (out_o.last)
);
